FILE: rtl/core/bptc_pkg.sv
`timescale 1ns / 1ps

package bptc_pkg;

	localparam int RAW_W  = 24;
	localparam int COEF_W = 16;
	localparam int TEMP_W = 20;
	localparam int PRES_W = 32;
	localparam int DT_W   = 25;
	localparam int TA_W   = 19;
	localparam int T2_W   = 17;
	localparam int ACC_W  = 40;

	// Temperature reference point (20.00 degrees) and the distance from it to -15.00 degrees.
	localparam logic signed [TEMP_W-1:0] TEMP_REF   = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] COLD_SHIFT = 20'sd3500;

	typedef enum logic [2:0] {
		REG_SENS       = 3'd0,
		REG_OFFSET     = 3'd1,
		REG_SENS_TC    = 3'd2,
		REG_OFFSET_TC  = 3'd3,
		REG_REF_TEMP   = 3'd4,
		REG_TEMP_SLOPE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] sens_coeff;
		logic [COEF_W-1:0] offset_coeff;
		logic [COEF_W-1:0] sens_temp_coeff;
		logic [COEF_W-1:0] offset_temp_coeff;
		logic [COEF_W-1:0] ref_temp_coeff;
		logic [COEF_W-1:0] temp_slope_coeff;
	} cfg_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} in_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_centideg;
		logic signed [PRES_W-1:0] pressure_pa;
	} out_t;

	// First-order results leaving the front stages.
	typedef struct packed {
		logic                    valid;
		logic [RAW_W-1:0]        d1;
		logic signed [TA_W-1:0]  ta;
		logic [T2_W-1:0]         t2;
		logic [ACC_W-1:0]        off;
		logic [ACC_W-1:0]        sens;
	} first_t;

	// Corrected temperature, offset and sensitivity.
	typedef struct packed {
		logic                      valid;
		logic [RAW_W-1:0]          d1;
		logic signed [TEMP_W-1:0]  temp;
		logic [ACC_W-1:0]          off;
		logic [ACC_W-1:0]          sens;
	} second_t;

endpackage

FILE: rtl/core/bptc_regs.sv
`timescale 1ns / 1ps

module bptc_regs (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_idx,
	input  logic [15:0]            cfg_data,
	output bptc_pkg::cfg_t         cfg
);

	bptc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (bptc_pkg::reg_idx_t'(cfg_idx))
				bptc_pkg::REG_SENS:       cfg_q.sens_coeff        <= cfg_data;
				bptc_pkg::REG_OFFSET:     cfg_q.offset_coeff      <= cfg_data;
				bptc_pkg::REG_SENS_TC:    cfg_q.sens_temp_coeff   <= cfg_data;
				bptc_pkg::REG_OFFSET_TC:  cfg_q.offset_temp_coeff <= cfg_data;
				bptc_pkg::REG_REF_TEMP:   cfg_q.ref_temp_coeff    <= cfg_data;
				bptc_pkg::REG_TEMP_SLOPE: cfg_q.temp_slope_coeff  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bptc_first.sv
`timescale 1ns / 1ps

module bptc_first (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  bptc_pkg::in_t      sample,
	input  bptc_pkg::cfg_t     cfg,
	output bptc_pkg::first_t   s3
);

	logic                     v_s1, v_s2, v_s3;
	logic [23:0]              d1_s1, d1_s2, d1_s3;
	logic signed [24:0]       dt_s1;
	logic signed [41:0]       tc_s2, oc_s2, sc_s2;
	logic signed [49:0]       dd_s2;
	logic signed [18:0]       ta_s3;
	logic [16:0]              t2_s3;
	logic [39:0]              off_s3, sens_s3;

	logic [41:0]              tc_b, oc_b, sc_b;
	logic [34:0]              off_lo;
	logic [33:0]              sens_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: temperature difference to the reference reading.
	always_ff @(posedge clk) begin
		d1_s1 <= sample.raw_pressure;
		dt_s1 <= $signed({1'b0, sample.raw_temperature})
			- $signed({1'b0, cfg.ref_temp_coeff, 8'b0});
	end

	// Stage 2: the four products of dT.
	always_ff @(posedge clk) begin
		d1_s2 <= d1_s1;
		tc_s2 <= dt_s1 * $signed({1'b0, cfg.temp_slope_coeff});
		oc_s2 <= dt_s1 * $signed({1'b0, cfg.offset_temp_coeff});
		sc_s2 <= dt_s1 * $signed({1'b0, cfg.sens_temp_coeff});
		dd_s2 <= dt_s1 * dt_s1;
	end

	// Shifts round toward zero: a negative value gets a bias of one below the divisor.
	always_comb begin
		tc_b    = tc_s2 + {19'b0, {23{tc_s2[41]}}};
		oc_b    = oc_s2 + {35'b0, {7{oc_s2[41]}}};
		sc_b    = sc_s2 + {34'b0, {8{sc_s2[41]}}};
		off_lo  = oc_b[41:7];
		sens_lo = sc_b[41:8];
	end

	// Stage 3: first-order temperature delta, offset and sensitivity.
	always_ff @(posedge clk) begin
		d1_s3   <= d1_s2;
		ta_s3   <= tc_b[41:23];
		t2_s3   <= dd_s2[47:31];
		off_s3  <= {8'b0, cfg.offset_coeff, 16'b0} + {{5{off_lo[34]}}, off_lo};
		sens_s3 <= {9'b0, cfg.sens_coeff, 15'b0} + {{6{sens_lo[33]}}, sens_lo};
	end

	assign s3.valid = v_s3;
	assign s3.d1    = d1_s3;
	assign s3.ta    = ta_s3;
	assign s3.t2    = t2_s3;
	assign s3.off   = off_s3;
	assign s3.sens  = sens_s3;

endmodule

FILE: rtl/core/bptc_second.sv
`timescale 1ns / 1ps

module bptc_second (
	input  logic               clk,
	input  logic               arst_n,
	input  bptc_pkg::first_t   f,
	output bptc_pkg::second_t  s6
);

	logic                 v_s4, v_s5, v_s6;
	logic                 low_s4, vlow_s4, low_s5;
	logic [23:0]          d1_s4, d1_s5, d1_s6;
	logic signed [18:0]   ta_s4;
	logic [16:0]          t2_s4;
	logic [39:0]          off_s4, sens_s4, off_s5, sens_s5, off_s6, sens_s6;
	logic signed [37:0]   a_s4;
	logic signed [39:0]   b_s4;
	logic [39:0]          off2_s5, sens2_s5;
	logic signed [19:0]   temp_s5, temp_s6;

	logic [19:0]          tb;
	logic [39:0]          a40, a5, b7, b11;

	// tb is the temperature minus -15.00 degrees.
	assign tb = {f.ta[18], f.ta} + bptc_pkg::COLD_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= f.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 4: squared distances below 20.00 and below -15.00 degrees.
	always_ff @(posedge clk) begin
		d1_s4   <= f.d1;
		ta_s4   <= f.ta;
		t2_s4   <= f.t2;
		off_s4  <= f.off;
		sens_s4 <= f.sens;
		low_s4  <= f.ta[18];
		vlow_s4 <= tb[19];
		a_s4    <= f.ta * f.ta;
		b_s4    <= $signed(tb) * $signed(tb);
	end

	// Both squares are non-negative, so plain shifts give the truncated quotients.
	always_comb begin
		a40 = {2'b0, a_s4};
		a5  = a40 + {a40[37:0], 2'b0};
		b7  = {b_s4[36:0], 3'b0} - b_s4;
		b11 = {b_s4[36:0], 3'b0} + {b_s4[38:0], 1'b0} + b_s4;
	end

	// Stage 5: second-order terms and final temperature.
	always_ff @(posedge clk) begin
		d1_s5   <= d1_s4;
		off_s5  <= off_s4;
		sens_s5 <= sens_s4;
		low_s5  <= low_s4;
		temp_s5 <= {ta_s4[18], ta_s4} + bptc_pkg::TEMP_REF
			- (low_s4 ? {3'b0, t2_s4} : 20'd0);
		if (low_s4) begin
			off2_s5  <= {1'b0, a5[39:1]} + (vlow_s4 ? b7 : 40'd0);
			sens2_s5 <= {2'b0, a5[39:2]} + (vlow_s4 ? {1'b0, b11[39:1]} : 40'd0);
		end else begin
			off2_s5  <= '0;
			sens2_s5 <= '0;
		end
	end

	// Stage 6: apply the corrections.
	always_ff @(posedge clk) begin
		d1_s6   <= d1_s5;
		temp_s6 <= temp_s5;
		off_s6  <= off_s5 - off2_s5;
		sens_s6 <= sens_s5 - sens2_s5;
	end

	assign s6.valid = v_s6;
	assign s6.d1    = d1_s6;
	assign s6.temp  = temp_s6;
	assign s6.off   = off_s6;
	assign s6.sens  = sens_s6;

`ifndef SYNTHESIS
	a_cold_below_ref: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && vlow_s4 |-> low_s4)
		else $error("item below -15.00 degrees not flagged below 20.00 degrees");

	a_cold_temp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && low_s5 |-> temp_s5 < bptc_pkg::TEMP_REF)
		else $error("cold item produced a temperature at or above 20.00 degrees");
`endif

endmodule

FILE: rtl/core/bptc_press.sv
`timescale 1ns / 1ps

module bptc_press (
	input  logic                clk,
	input  logic                arst_n,
	input  bptc_pkg::second_t   c,
	output logic                valid,
	output bptc_pkg::out_t      result
);

	logic                 v_s7, v_s8, v_s9, v_s10, v_s11;
	logic signed [19:0]   temp_s7, temp_s8, temp_s9, temp_s10;
	logic [39:0]          off_s7, off_s8, off_s9;
	logic [43:0]          p_lo_s7;
	logic signed [44:0]   p_hi_s7;
	logic [63:0]          prod_s8;
	logic [42:0]          q_s9;
	logic [43:0]          diff_s10;
	bptc_pkg::out_t       res_s11;

	logic [63:0]          qb;
	logic [43:0]          pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s7  <= c.valid;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// The 24 x 40 bit product is formed from two partial products over two stages.
	always_ff @(posedge clk) begin
		temp_s7 <= c.temp;
		off_s7  <= c.off;
		p_lo_s7 <= c.d1 * c.sens[19:0];
		p_hi_s7 <= $signed({1'b0, c.d1}) * $signed(c.sens[39:20]);
	end

	always_ff @(posedge clk) begin
		temp_s8 <= temp_s7;
		off_s8  <= off_s7;
		prod_s8 <= {p_hi_s7[43:0], 20'b0} + {20'b0, p_lo_s7};
	end

	assign qb = prod_s8 + {43'b0, {21{prod_s8[63]}}};

	always_ff @(posedge clk) begin
		temp_s9 <= temp_s8;
		off_s9  <= off_s8;
		q_s9    <= qb[63:21];
	end

	always_ff @(posedge clk) begin
		temp_s10 <= temp_s9;
		diff_s10 <= {q_s9[42], q_s9} - {{4{off_s9[39]}}, off_s9};
	end

	assign pb = diff_s10 + {29'b0, {15{diff_s10[43]}}};

	// The quotient fits in 29 bits for any inputs, so the 32-bit clamp reduces to
	// sign extension.
	always_ff @(posedge clk) begin
		res_s11.temp_centideg <= temp_s10;
		res_s11.pressure_pa   <= {{3{pb[43]}}, pb[43:15]};
	end

	assign valid  = v_s11;
	assign result = res_s11;

endmodule

FILE: rtl/core/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfer when        Payload
// sample    in         start && !busy       raw_pressure, raw_temperature
// result    out        valid (one cycle)    temp_centideg, pressure_pa
// cfg       in         cfg_we               cfg_idx selects, cfg_data low 16 bits
//
// An 11-stage pipeline: a sample passes through registers s1 to s11 before its result appears.
// One sample can be taken in every cycle; busy stays low.
// The depth is set by the chain of dependent multiplies (dT products, squares,
// the two partial products of D1 times SENS) with a register after each.
// Reset clears the calibration words and drops every item in flight.
// The receiver cannot stall, so the pipeline always advances.
module baro_pressure_temp_compensation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bptc_pkg::in_t     sample,
	output logic              valid,
	output bptc_pkg::out_t    result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [15:0]       cfg_data
);

	bptc_pkg::cfg_t     cfg;
	bptc_pkg::first_t   first;
	bptc_pkg::second_t  second;
	logic               accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	bptc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	bptc_first u_first (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample),
		.cfg    (cfg),
		.s3     (first)
	);

	bptc_second u_second (
		.clk    (clk),
		.arst_n (arst_n),
		.f      (first),
		.s6     (second)
	);

	bptc_press u_press (
		.clk    (clk),
		.arst_n (arst_n),
		.c      (second),
		.valid  (valid),
		.result (result)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##11 valid)
		else $error("accepted sample did not produce a result after 11 cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(start && !busy, 11))
		else $error("result strobe without a sample taken 11 cycles earlier");
`endif

endmodule
